### rtl/aacsdp_pkg.sv
package aacsdp_pkg;

    // Frame geometry
    localparam int MAX_BANDS       = 51;
    localparam int LEN_FIELD_BITS  = 5;
    localparam int BOOK_FIELD_BITS = 4;

    localparam int BAND_W  = 6;
    localparam int BOOK_W  = 4;
    localparam int SHIFT_W = (LEN_FIELD_BITS > BOOK_FIELD_BITS) ? LEN_FIELD_BITS
                                                                : BOOK_FIELD_BITS;
    localparam int CNT_W   = $clog2(SHIFT_W + 1);
    localparam int LEN_W   = 7;              // escape sums saturate at 64
    localparam int SUM_W   = 8;

    localparam logic [LEN_FIELD_BITS-1:0] LEN_ESCAPE = '1;
    localparam logic [LEN_W-1:0]          LEN_SAT    = LEN_W'(64);
    localparam logic [BOOK_W-1:0]         SCF_BOOK   = BOOK_W'(12);
    localparam logic [BAND_W-1:0]         MAX_BAND_V = BAND_W'(MAX_BANDS);

    // Stream word layout
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Result kinds
    typedef enum logic [1:0] {
        RES_BAND     = 2'd0,
        RES_DONE     = 2'd1,
        RES_ERR_LEN  = 2'd2,
        RES_ERR_BOOK = 2'd3
    } t_res_kind;

    typedef struct packed {
        t_res_kind          kind;
        logic [BAND_W-1:0]  band;
        logic [BOOK_W-1:0]  book;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOOK,
        ST_LEN,
        ST_SECT,
        ST_FILL
    } t_state;

endpackage

### rtl/aac_section_data_parser.sv
// AAC long-window section data parser. A word with tuser set starts a frame and
// loads the transmitted and total band counts; every other word carries one
// bitstream bit in tdata[0], MSB first within each field. Sections are read as
// a 4-bit codebook and a 5-bit length (all ones = escape, another length field
// follows). When a section closes, one result per band it covers is streamed
// out with its codebook; after the transmitted bands, the remaining bands up to
// the total (capped at 51) follow with codebook 0 and then a done result. A
// section running past band 51, or a nonempty section with codebook 12, ends
// the frame with a single error result. A bit word that does not close a
// section, or that ends the frame with an error result, is taken without
// holding the input off. A word that closes a section holds the input off
// while one result per band it covers is streamed out, and through a
// turnaround state after the section's bands; when it also closes the frame,
// the zero fill and the done result are part of that same burst. A start word
// with no transmitted bands holds the input off through the zero fill and the
// done result. The single result register sets the pace; while the output is
// stalled, the input is held off as well.
module aac_section_data_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] bit_value, [6:1] transmitted_bands, [12:7] total_bands, [15:13] zero
    input  logic [aacsdp_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [0] kind (1 = frame start)
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] band_index, [9:6] codebook, [15:10] zero
    output logic [aacsdp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] result_kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import aacsdp_pkg::*;

    t_state              r_state, n_state;
    logic [SHIFT_W-1:0]  r_shift, n_shift;   // field shift register, one bit per word
    logic [CNT_W-1:0]    r_bits,  n_bits;    // bits still to come in this field
    logic [BOOK_W-1:0]   r_book,  n_book;
    logic [LEN_W-1:0]    r_len,   n_len;     // running escape sum
    logic [BAND_W-1:0]   r_band,  n_band;
    logic [BAND_W-1:0]   r_top,   n_top;     // end of section being emitted
    logic [BAND_W-1:0]   r_sent,  n_sent;
    logic [BAND_W-1:0]   r_all,   n_all;
    logic                r_out_valid, n_out_valid;
    t_result             r_out,   n_out;

    logic                out_free;
    logic                in_accept;
    logic                in_bit;
    logic [BAND_W-1:0]   in_sent;
    logic [BAND_W-1:0]   in_all;
    logic [SHIFT_W-1:0]  shifted;
    logic [LEN_FIELD_BITS-1:0] len_field;
    logic [SUM_W-1:0]    len_sum;
    logic [LEN_W-1:0]    len_sat;
    logic [SUM_W-1:0]    sect_end;
    logic [BAND_W:0]     band_inc;
    logic [BAND_W-1:0]   fill_limit;

    assign in_bit  = s_axis_tdata[0];
    assign in_sent = s_axis_tdata[BAND_W:1];
    assign in_all  = s_axis_tdata[2*BAND_W:BAND_W+1];

    // result register frees up when empty or being taken this cycle
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = out_free &&
                           (r_state == ST_IDLE || r_state == ST_BOOK || r_state == ST_LEN);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign shifted    = {r_shift[SHIFT_W-2:0], in_bit};
    assign len_field  = shifted[LEN_FIELD_BITS-1:0];
    assign len_sum    = SUM_W'(r_len) + SUM_W'(len_field);
    assign len_sat    = (len_sum > SUM_W'(LEN_SAT)) ? LEN_SAT : len_sum[LEN_W-1:0];
    assign sect_end   = SUM_W'(r_band) + SUM_W'(len_sat);
    assign band_inc   = {1'b0, r_band} + (BAND_W+1)'(1);
    assign fill_limit = (r_all > MAX_BAND_V) ? MAX_BAND_V : r_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_bits      <= '0;
            r_shift     <= '0;
            r_book      <= '0;
            r_len       <= '0;
            r_band      <= '0;
            r_top       <= '0;
            r_sent      <= '0;
            r_all       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_bits      <= n_bits;
            r_shift     <= n_shift;
            r_book      <= n_book;
            r_len       <= n_len;
            r_band      <= n_band;
            r_top       <= n_top;
            r_sent      <= n_sent;
            r_all       <= n_all;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_shift     = r_shift;
        n_bits      = r_bits;
        n_book      = r_book;
        n_len       = r_len;
        n_band      = r_band;
        n_top       = r_top;
        n_sent      = r_sent;
        n_all       = r_all;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;

        case (r_state)
            ST_IDLE, ST_BOOK, ST_LEN: begin
                if (in_accept && s_axis_tuser) begin
                    // frame start, also restarts a frame in progress
                    n_sent  = in_sent;
                    n_all   = in_all;
                    n_band  = '0;
                    n_len   = '0;
                    n_book  = '0;
                    n_shift = '0;
                    if (in_sent == '0) begin
                        n_bits  = '0;
                        n_state = ST_FILL;
                    end else begin
                        n_bits  = CNT_W'(BOOK_FIELD_BITS);
                        n_state = ST_BOOK;
                    end
                end else if (in_accept && r_state != ST_IDLE) begin
                    n_shift = shifted;
                    n_bits  = r_bits - CNT_W'(1);
                    if (r_bits == CNT_W'(1)) begin
                        n_shift = '0;
                        if (r_state == ST_BOOK) begin
                            n_book  = shifted[BOOK_W-1:0];
                            n_len   = '0;
                            n_bits  = CNT_W'(LEN_FIELD_BITS);
                            n_state = ST_LEN;
                        end else if (len_field == LEN_ESCAPE) begin
                            n_len  = len_sat;
                            n_bits = CNT_W'(LEN_FIELD_BITS);
                        end else if (sect_end > SUM_W'(MAX_BANDS)) begin
                            n_out_valid = 1'b1;
                            n_out       = '{kind: RES_ERR_LEN, band: r_band,
                                            book: r_book, last: 1'b1};
                            n_state     = ST_IDLE;
                        end else if (len_sat != '0 && r_book == SCF_BOOK) begin
                            n_out_valid = 1'b1;
                            n_out       = '{kind: RES_ERR_BOOK, band: r_band,
                                            book: r_book, last: 1'b1};
                            n_state     = ST_IDLE;
                        end else begin
                            n_top   = sect_end[BAND_W-1:0];
                            n_len   = '0;
                            n_state = ST_SECT;
                        end
                    end
                end
            end

            ST_SECT: begin
                if (r_band != r_top) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        // last band closes the word unless fill/done follows
                        n_out       = '{kind: RES_BAND, band: r_band, book: r_book,
                                        last: (band_inc == {1'b0, r_top}) &&
                                              (band_inc < {1'b0, r_sent})};
                        n_band      = band_inc[BAND_W-1:0];
                    end
                end else if (r_band >= r_sent) begin
                    n_state = ST_FILL;
                end else begin
                    n_shift = '0;
                    n_bits  = CNT_W'(BOOK_FIELD_BITS);
                    n_state = ST_BOOK;
                end
            end

            ST_FILL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_band < fill_limit) begin
                        n_out  = '{kind: RES_BAND, band: r_band, book: '0, last: 1'b0};
                        n_band = band_inc[BAND_W-1:0];
                    end else begin
                        n_out   = '{kind: RES_DONE, band: r_band, book: '0, last: 1'b1};
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {(OUT_DATA_W-BAND_W-BOOK_W)'(0), r_out.book, r_out.band};

endmodule

### rtl/aacsdp_checker.sv
module aacsdp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [aacsdp_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [aacsdp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import aacsdp_pkg::*;

    // nothing is left in the result register after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled result changed");

    // done and error results always close the word's results
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == RES_DONE || m_axis_tuser == RES_ERR_LEN ||
                          m_axis_tuser == RES_ERR_BOOK) |-> m_axis_tlast)
        else $error("frame end without tlast");

    // assigned bands stay inside the band limit
    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == RES_BAND |->
            m_axis_tdata[BAND_W-1:0] < MAX_BAND_V)
        else $error("band index out of range");

    // done results carry codebook 0
    a_done_book: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == RES_DONE |->
            m_axis_tdata[BAND_W+BOOK_W-1:BAND_W] == '0)
        else $error("done with nonzero codebook");

endmodule

bind aac_section_data_parser aacsdp_checker u_aacsdp_checker (.*);

### test/section_result_checker.sv
// Watches both stream channels of the section data parser, predicts each
// result from the accepted input words and compares in order.
module section_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [0] bit_value, [6:1] transmitted_bands, [12:7] total_bands, [15:13] zero
    input  logic [aacsdp_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [0] kind (1 = frame start)
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] band_index, [9:6] codebook, [15:10] zero
    input  logic [aacsdp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] result_kind
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import aacsdp_pkg::*;

    // parser state as this side sees it
    t_state             parse_phase;
    logic [2:0]         bits_to_go;
    logic [5:0]         field_acc;
    logic [BOOK_W-1:0]  cur_book;
    logic [LEN_W-1:0]   cur_len;
    logic [BAND_W-1:0]  next_band;
    logic [BAND_W-1:0]  sent_bands;
    logic [BAND_W-1:0]  total_bands;

    t_result            section_results_due[$];
    int                 mismatches = 0;
    int                 results_due_n = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = results_due_n;

    task automatic post_result(input t_res_kind k, input logic [BAND_W-1:0] band,
                               input logic [BOOK_W-1:0] book);
        t_result r;
        r.kind = k;
        r.band = band;
        r.book = book;
        r.last = 1'b0;
        section_results_due.push_back(r);
    endtask

    // zero fill up to the total (capped), then done
    task automatic close_frame();
        int fill_end;
        fill_end = (total_bands > MAX_BANDS) ? MAX_BANDS : int'(total_bands);
        while (next_band < fill_end) begin
            post_result(RES_BAND, next_band, '0);
            next_band++;
        end
        post_result(RES_DONE, next_band, '0);
        parse_phase = ST_IDLE;
    endtask

    task automatic parse_word(input logic is_start, input logic bit_in,
                              input logic [BAND_W-1:0] sent, input logic [BAND_W-1:0] total);
        int n_before;
        int len_sum;
        int band_end;
        n_before = section_results_due.size();
        if (is_start) begin
            sent_bands  = sent;
            total_bands = total;
            next_band   = '0;
            cur_len     = '0;
            cur_book    = '0;
            field_acc   = '0;
            if (sent == 0) begin
                bits_to_go = '0;
                close_frame();
            end else begin
                parse_phase = ST_BOOK;
                bits_to_go  = 3'(BOOK_FIELD_BITS);
            end
        end else if (parse_phase != ST_IDLE) begin
            field_acc = {field_acc[4:0], bit_in};
            if (bits_to_go != 0)
                bits_to_go--;
            if (bits_to_go == 0) begin
                if (parse_phase == ST_BOOK) begin
                    cur_book    = field_acc[BOOK_W-1:0];
                    cur_len     = '0;
                    parse_phase = ST_LEN;
                    bits_to_go  = 3'(LEN_FIELD_BITS);
                    field_acc   = '0;
                end else begin
                    len_sum = int'(cur_len) + int'(field_acc);
                    if (len_sum > LEN_SAT)
                        len_sum = LEN_SAT;
                    if (field_acc == LEN_ESCAPE) begin
                        // escape: keep summing, another length field follows
                        cur_len    = LEN_W'(len_sum);
                        bits_to_go = 3'(LEN_FIELD_BITS);
                        field_acc  = '0;
                    end else begin
                        band_end = int'(next_band) + len_sum;
                        if (band_end > MAX_BANDS) begin
                            post_result(RES_ERR_LEN, next_band, cur_book);
                            parse_phase = ST_IDLE;
                        end else if (len_sum > 0 && cur_book == SCF_BOOK) begin
                            post_result(RES_ERR_BOOK, next_band, cur_book);
                            parse_phase = ST_IDLE;
                        end else begin
                            while (next_band < band_end) begin
                                post_result(RES_BAND, next_band, cur_book);
                                next_band++;
                            end
                            cur_len   = '0;
                            field_acc = '0;
                            if (next_band >= sent_bands) begin
                                bits_to_go = '0;
                                close_frame();
                            end else begin
                                parse_phase = ST_BOOK;
                                bits_to_go  = 3'(BOOK_FIELD_BITS);
                            end
                        end
                    end
                end
            end
        end
        if (section_results_due.size() > n_before)
            section_results_due[section_results_due.size()-1].last = 1'b1;
    endtask

    task automatic check_result();
        t_result want;
        t_result got;
        got.kind = t_res_kind'(m_axis_tuser);
        got.band = m_axis_tdata[BAND_W-1:0];
        got.book = m_axis_tdata[BAND_W+BOOK_W-1:BAND_W];
        got.last = m_axis_tlast;
        if (section_results_due.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: unexpected result kind %0d band %0d book %0d last %0d",
                         $realtime, got.kind, got.band, got.book, got.last);
            mismatches++;
        end else begin
            want = section_results_due.pop_front();
            if (got.kind !== want.kind || got.band !== want.band ||
                got.book !== want.book || got.last !== want.last) begin
                if (mismatches < 10)
                    $display("%0t: expected kind %0d band %0d book %0d last %0d, got kind %0d band %0d book %0d last %0d",
                             $realtime, want.kind, want.band, want.book, want.last,
                             got.kind, got.band, got.book, got.last);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_phase = ST_IDLE;
            bits_to_go  = '0;
            field_acc   = '0;
            cur_book    = '0;
            cur_len     = '0;
            next_band   = '0;
            sent_bands  = '0;
            total_bands = '0;
            section_results_due.delete();
        end else begin
            // results leave before words of this edge can cause new ones
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                parse_word(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[6:1],
                           s_axis_tdata[12:7]);
        end
        results_due_n = section_results_due.size();
    end

endmodule

### test/tb_top.sv
// Stimulus and verdict for the section data parser. The checker beside the
// DUT does all prediction; this module only feeds words and drains results.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aacsdp_pkg::*;

    localparam int RANDOM_WORDS = 250;
    localparam int TAIL_CYCLES  = 64;   // covers the longest result burst

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [0] bit_value, [6:1] transmitted_bands, [12:7] total_bands, [15:13] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [0] kind (1 = frame start)
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [5:0] band_index, [9:6] codebook, [15:10] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [1:0] result_kind
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int          fail_count;
    int          pending;

    // sender burst bookkeeping
    int          burst_left = 0;
    int          words_sent = 0;

    // receiver stall pattern
    bit          drain_all = 1'b0;
    int          stall_mode = 0;
    int          stall_mode_left = 0;
    logic [1:0]  stall_tick = '0;

    aac_section_data_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    section_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop, well past the slowest legal run (every word with a full
    // 52-result burst, each result stalled).
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Receiver: modes of always ready, coin flip, one-in-four and mostly
    // ready, each held for a random stretch. Forced ready while draining.
    always @(posedge i_clk) begin
        if (drain_all) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (stall_mode_left == 0) begin
                stall_mode      = $urandom_range(0, 3);
                stall_mode_left = $urandom_range(16, 96);
            end
            stall_mode_left--;
            stall_tick++;
            case (stall_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_axis_tready <= (stall_tick == 2'd0);
                end
                default: begin
                    m_axis_tready <= ($urandom_range(0, 7) != 0);
                end
            endcase
        end
    end

    // One word per call, returns at the edge that accepted it. Bursts of
    // 1..16 words, then a gap; about a quarter of the bursts run back to back.
    task automatic send_word(input logic kind, input logic bit_in,
                             input logic [BAND_W-1:0] sent, input logic [BAND_W-1:0] total);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                // only lower valid when a real gap follows
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, total, sent, bit_in};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        words_sent++;
    endtask

    // bitstream word; the band count fields are don't-care, so fill them with noise
    task automatic send_bit(input logic bit_in);
        send_word(1'b0, bit_in, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    endtask

    task automatic send_start(input int sent, input int total);
        send_word(1'b1, 1'($urandom_range(0, 1)), 6'(sent), 6'(total));
    endtask

    // MSB first
    task automatic send_field(input int value, input int nbits);
        for (int i = nbits - 1; i >= 0; i--)
            send_bit(value[i]);
    endtask

    // codebook, then length split into escape fields of all ones
    task automatic send_section(input int book, input int len);
        int rest;
        rest = len;
        send_field(book, BOOK_FIELD_BITS);
        while (rest >= LEN_ESCAPE) begin
            send_field(LEN_ESCAPE, LEN_FIELD_BITS);
            rest -= LEN_ESCAPE;
        end
        send_field(rest, LEN_FIELD_BITS);
    endtask

    initial begin
        int  sent;
        int  total;
        int  book;
        int  len;
        int  band_pos;
        int  pick;
        bit  frame_open;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        send_bit(1'b1);              // bit while idle: dropped
        send_start(0, 0);            // nothing transmitted, nothing to fill: done only
        send_start(0, 63);           // fill capped at band 51, longest burst
        send_start(1, 63);
        send_section(SCF_BOOK, 0);   // empty scalefactor section is legal
        send_section(SCF_BOOK, 1);   // nonempty one ends the frame with an error

        // --- random frames ---
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                sent = 0;
            else if (pick == 1)
                sent = $urandom_range(MAX_BANDS + 1, 63);  // runs until a length error
            else if (pick == 2)
                sent = $urandom_range(13, MAX_BANDS);
            else
                sent = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0)
                total = $urandom_range(0, 63);
            else
                total = (sent + $urandom_range(0, 8) > 63) ? 63 : sent + $urandom_range(0, 8);
            send_start(sent, total);

            // broken frame: a few raw bits, then the next start restarts it
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 12)) send_bit(1'($urandom_range(0, 1)));
                continue;
            end

            band_pos   = 0;
            frame_open = (sent != 0);
            while (frame_open && words_sent < RANDOM_WORDS) begin
                book = $urandom_range(0, 15);
                if (book == SCF_BOOK && $urandom_range(0, 2) != 0)
                    book = $urandom_range(0, 11);
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    len = $urandom_range(MAX_BANDS + 1, 100);  // overflow, sums saturate
                else if (pick < 3)
                    len = $urandom_range(LEN_ESCAPE, 50);      // one or more escapes
                else if (pick == 3)
                    len = 0;
                else
                    len = $urandom_range(1, 8);
                send_section(book, len);
                // frame ends on a length error, a scalefactor book or full coverage
                if (band_pos + len > MAX_BANDS || (book == SCF_BOOK && len > 0) ||
                    band_pos + len >= sent)
                    frame_open = 1'b0;
                band_pos += len;
            end

            // stray bits after a closed frame are dropped and do not count
            if (!frame_open && $urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_bit(1'($urandom_range(0, 1)));
                    words_sent--;
                end
            end
        end

        s_axis_tvalid <= 1'b0;

        // drain, then a quiet tail to catch stray results
        @(negedge i_clk);
        drain_all = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
